### hdl/dmxdf_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the lighting delta-frame decoder.
// No dependencies.
package dmxdf_pkg;

    localparam int SLOTS = 512;
    localparam int GROUPS = SLOTS / 8;
    localparam int KEY_MIN_LEN = 513;
    localparam int BM_HDR_LEN = 65;
    localparam int RG_HDR_LEN = 5;

    localparam logic [3:0] TYPE_KEY    = 4'h1;
    localparam logic [3:0] TYPE_SPARSE = 4'h2;
    localparam logic [3:0] TYPE_BITMAP = 4'h3;
    localparam logic [3:0] TYPE_RANGE  = 4'h4;
    localparam logic [3:0] TYPE_KEEP   = 4'h5;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_EMPTY       = 4'd1;
    localparam logic [3:0] ST_KEY_SHORT   = 4'd2;
    localparam logic [3:0] ST_SYNC_LOST   = 4'd3;
    localparam logic [3:0] ST_SPARSE_SHORT = 4'd4;
    localparam logic [3:0] ST_BM_HDR_SHORT = 4'd5;
    localparam logic [3:0] ST_BM_DATA_SHORT = 4'd6;
    localparam logic [3:0] ST_RG_HDR_SHORT = 4'd7;
    localparam logic [3:0] ST_RG_BAD      = 4'd8;
    localparam logic [3:0] ST_UNKNOWN     = 4'd9;

endpackage

### hdl/dmx_delta_frame_decoder_core.sv
`timescale 1ns / 1ps
// Delta-frame decoder top level: frame buffer, universe store and decode sequencer.
// Depends on dmxdf_pkg and dmxdf_ram.
//
// channel | dir | tdata (low bit up)                          | tuser        | tlast
// s_      | in  | frame_byte[7:0]                             | byte_present | frame_last
// m_      | out | status[3:0] group_index[9:4] slot_group[73:10] | -          | result_last
//
// A byte word is accepted whenever s_tready is high. A frame end starts the decode, which
// reads the frame buffer one byte a cycle (bitmap frames: a read of each map byte, then a
// bit test for each slot and a data read for each set slot), then reads the universe back
// at one slot a cycle when the output is not stalled, one result group at a time.
// After reset a sweep zeroes all 512 universe slots; s_tready stays low meanwhile and
// during any decode. Output stalls hold the sequencer at the result register.
module dmx_delta_frame_decoder_core #(
    parameter int FRAME_STORE_DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // frame_byte[7:0]
    input  logic        s_tuser,   // byte_present
    input  logic        s_tlast,   // frame_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // status[3:0], group_index[9:4], slot_group[73:10]
    output logic        m_tlast    // result_last
);
    import dmxdf_pkg::*;

    localparam int AW = $clog2(FRAME_STORE_DEPTH);
    localparam int PW = AW + 1;

    typedef enum logic [17:0] {
        S_CLEAR    = 18'h00001,
        S_IDLE     = 18'h00002,
        S_H0       = 18'h00004,
        S_H1       = 18'h00008,
        S_KEY      = 18'h00010,
        S_SP_CNT   = 18'h00020,
        S_SP_HI    = 18'h00040,
        S_SP_LO    = 18'h00080,
        S_SP_VAL   = 18'h00100,
        S_BM_MAP   = 18'h00200,
        S_BM_BIT   = 18'h00400,
        S_BM_DAT   = 18'h00800,
        S_RG_HDR   = 18'h01000,
        S_RG_CHK   = 18'h02000,
        S_RG_WR    = 18'h04000,
        S_OUT_RD   = 18'h08000,
        S_OUT_SEND = 18'h10000,
        S_ERR      = 18'h20000
    } state_t;

    state_t       state_reg, state_next;
    logic [15:0]  len_reg, len_next;
    logic [PW-1:0] ptr_reg, ptr_next;
    logic [9:0]   cnt_reg, cnt_next;
    logic [8:0]   widx_reg, widx_next;
    logic [15:0]  off_reg, off_next;
    logic [31:0]  sh_reg, sh_next;
    logic [63:0]  acc_reg, acc_next;
    logic [5:0]   grp_reg, grp_next;
    logic [3:0]   code_reg, code_next;
    logic [3:0]   lseq_reg, lseq_next;
    logic         seen_reg, seen_next;
    logic         lost_reg, lost_next;
    logic         mv_reg, mv_next;
    logic [79:0]  md_reg, md_next;
    logic         ml_reg, ml_next;

    logic         fs_we;
    logic [7:0]   fs_rdata, rd;
    logic         uwe;
    logic [8:0]   uwaddr, uraddr;
    logic [7:0]   uwdata, urdata;

    logic         acc_in, out_free, gap, bit_on;
    logic [15:0]  len_inc;
    logic [3:0]   seq, ftype;
    logic [10:0]  sp_need;
    logic [16:0]  rg_need, rg_end;
    logic [8:0]   widx_inc;

    dmxdf_ram #(.WIDTH(8), .DEPTH(FRAME_STORE_DEPTH)) u_frame (
        .aclk(aclk), .we(fs_we), .waddr(len_reg[AW-1:0]), .wdata(s_tdata),
        .raddr(ptr_next[AW-1:0]), .rdata(fs_rdata)
    );

    dmxdf_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_univ (
        .aclk(aclk), .we(uwe), .waddr(uwaddr), .wdata(uwdata),
        .raddr(uraddr), .rdata(urdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign acc_in   = s_tvalid && s_tready;
    assign fs_we    = acc_in && s_tuser && (len_reg < 16'(FRAME_STORE_DEPTH));
    assign len_inc  = (s_tuser && len_reg != 16'hFFFF) ? len_reg + 16'd1 : len_reg;
    assign out_free = !mv_reg || m_tready;
    // bytes beyond the buffer read as zero
    assign rd       = (ptr_reg >= PW'(FRAME_STORE_DEPTH)) ? 8'd0 : fs_rdata;
    assign seq      = rd[7:4];
    assign ftype    = rd[3:0];
    assign gap      = seen_reg && (seq != lseq_reg + 4'd1) && (ftype != TYPE_KEY);
    assign sp_need  = {2'b0, rd, 1'b0} + {3'b0, rd} + 11'd2;
    assign rg_need  = {1'b0, sh_reg[15:0]} + 17'(RG_HDR_LEN);
    assign rg_end   = {1'b0, sh_reg[31:16]} + {1'b0, sh_reg[15:0]};
    assign widx_inc = widx_reg + 9'd1;
    assign bit_on   = sh_reg[widx_reg[2:0]];
    assign uraddr   = {grp_reg, cnt_reg[2:0]};

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;

    always_comb begin
        state_next = state_reg;
        len_next   = len_reg;
        ptr_next   = ptr_reg;
        cnt_next   = cnt_reg;
        widx_next  = widx_reg;
        off_next   = off_reg;
        sh_next    = sh_reg;
        acc_next   = acc_reg;
        grp_next   = grp_reg;
        code_next  = code_reg;
        lseq_next  = lseq_reg;
        seen_next  = seen_reg;
        lost_next  = lost_reg;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;
        ml_next    = ml_reg;
        uwe        = 1'b0;
        uwaddr     = widx_reg;
        uwdata     = rd;

        unique case (state_reg)
            S_CLEAR: begin
                uwe    = 1'b1;
                uwdata = 8'd0;
                widx_next = widx_inc;
                if (widx_reg == 9'(SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc_in) begin
                    len_next = len_inc;
                    if (s_tlast) begin
                        ptr_next = '0;
                        if (len_inc == 16'd0) begin
                            code_next  = ST_EMPTY;
                            state_next = S_ERR;
                        end else begin
                            state_next = S_H0;
                        end
                    end
                end
            end
            S_H0: begin
                state_next = S_H1;
            end
            S_H1: begin
                lseq_next = seq;
                seen_next = 1'b1;
                if (gap) begin
                    lost_next = 1'b1;
                end
                ptr_next  = PW'(1);
                widx_next = '0;
                cnt_next  = '0;
                if (ftype == TYPE_KEY) begin
                    if (len_reg < 16'(KEY_MIN_LEN)) begin
                        code_next  = ST_KEY_SHORT;
                        state_next = S_ERR;
                    end else begin
                        state_next = S_KEY;
                    end
                end else if (lost_reg || gap) begin
                    code_next  = ST_SYNC_LOST;
                    state_next = S_ERR;
                end else begin
                    case (ftype)
                        TYPE_SPARSE: state_next = S_SP_CNT;
                        TYPE_BITMAP: begin
                            off_next = 16'(BM_HDR_LEN);
                            if (len_reg < 16'(BM_HDR_LEN)) begin
                                code_next  = ST_BM_HDR_SHORT;
                                state_next = S_ERR;
                            end else begin
                                state_next = S_BM_MAP;
                            end
                        end
                        TYPE_RANGE: begin
                            if (len_reg < 16'(RG_HDR_LEN)) begin
                                code_next  = ST_RG_HDR_SHORT;
                                state_next = S_ERR;
                            end else begin
                                state_next = S_RG_HDR;
                            end
                        end
                        TYPE_KEEP: begin
                            grp_next   = '0;
                            state_next = S_OUT_RD;
                        end
                        default: begin
                            code_next  = ST_UNKNOWN;
                            state_next = S_ERR;
                        end
                    endcase
                end
            end
            S_KEY: begin
                uwe       = 1'b1;
                ptr_next  = ptr_reg + PW'(1);
                widx_next = widx_inc;
                if (widx_reg == 9'(SLOTS - 1)) begin
                    lost_next  = 1'b0;
                    grp_next   = '0;
                    cnt_next   = '0;
                    state_next = S_OUT_RD;
                end
            end
            S_SP_CNT: begin
                ptr_next = PW'(2);
                cnt_next = {2'b0, rd};
                if (len_reg < {5'b0, sp_need}) begin
                    code_next  = ST_SPARSE_SHORT;
                    state_next = S_ERR;
                end else if (rd == 8'd0) begin
                    grp_next   = '0;
                    cnt_next   = '0;
                    state_next = S_OUT_RD;
                end else begin
                    state_next = S_SP_HI;
                end
            end
            S_SP_HI: begin
                sh_next    = {sh_reg[23:0], rd};
                ptr_next   = ptr_reg + PW'(1);
                state_next = S_SP_LO;
            end
            S_SP_LO: begin
                sh_next    = {sh_reg[23:0], rd};
                ptr_next   = ptr_reg + PW'(1);
                state_next = S_SP_VAL;
            end
            S_SP_VAL: begin
                uwaddr   = sh_reg[8:0];
                uwe      = (sh_reg[15:0] < 16'(SLOTS));
                ptr_next = ptr_reg + PW'(1);
                cnt_next = cnt_reg - 10'd1;
                if (cnt_reg == 10'd1) begin
                    grp_next   = '0;
                    cnt_next   = '0;
                    state_next = S_OUT_RD;
                end else begin
                    state_next = S_SP_HI;
                end
            end
            S_BM_MAP: begin
                sh_next    = {sh_reg[31:8], rd};
                state_next = S_BM_BIT;
            end
            S_BM_BIT, S_BM_DAT: begin
                if (state_reg == S_BM_BIT && bit_on) begin
                    if (off_reg >= len_reg) begin
                        code_next  = ST_BM_DATA_SHORT;
                        state_next = S_ERR;
                    end else begin
                        ptr_next   = off_reg[PW-1:0];
                        state_next = S_BM_DAT;
                    end
                end else begin
                    if (state_reg == S_BM_DAT) begin
                        uwe      = 1'b1;
                        off_next = off_reg + 16'd1;
                    end
                    widx_next = widx_inc;
                    if (widx_reg == 9'(SLOTS - 1)) begin
                        grp_next   = '0;
                        cnt_next   = '0;
                        state_next = S_OUT_RD;
                    end else if (widx_reg[2:0] == 3'd7) begin
                        ptr_next   = PW'(1) + PW'(widx_inc[8:3]);
                        state_next = S_BM_MAP;
                    end else begin
                        state_next = S_BM_BIT;
                    end
                end
            end
            S_RG_HDR: begin
                sh_next  = {sh_reg[23:0], rd};
                ptr_next = ptr_reg + PW'(1);
                cnt_next = cnt_reg + 10'd1;
                if (cnt_reg == 10'd3) begin
                    state_next = S_RG_CHK;
                end
            end
            S_RG_CHK: begin
                widx_next = sh_reg[24:16];
                cnt_next  = sh_reg[9:0];
                ptr_next  = PW'(RG_HDR_LEN);
                if ({1'b0, len_reg} < rg_need || rg_end > 17'(SLOTS)) begin
                    code_next  = ST_RG_BAD;
                    state_next = S_ERR;
                end else if (sh_reg[15:0] == 16'd0) begin
                    grp_next   = '0;
                    cnt_next   = '0;
                    state_next = S_OUT_RD;
                end else begin
                    state_next = S_RG_WR;
                end
            end
            S_RG_WR: begin
                uwe       = 1'b1;
                widx_next = widx_inc;
                ptr_next  = ptr_reg + PW'(1);
                cnt_next  = cnt_reg - 10'd1;
                if (cnt_reg == 10'd1) begin
                    grp_next   = '0;
                    cnt_next   = '0;
                    state_next = S_OUT_RD;
                end
            end
            S_OUT_RD: begin
                // read issued at count c, data lands at c+1
                if (cnt_reg != 10'd0) begin
                    acc_next = {urdata, acc_reg[63:8]};
                end
                if (cnt_reg[3]) begin
                    state_next = S_OUT_SEND;
                end else begin
                    cnt_next = cnt_reg + 10'd1;
                end
            end
            S_OUT_SEND: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    md_next = {6'd0, acc_reg, grp_reg, ST_OK};
                    ml_next = (grp_reg == 6'(GROUPS - 1));
                    cnt_next = '0;
                    grp_next = grp_reg + 6'd1;
                    if (grp_reg == 6'(GROUPS - 1)) begin
                        len_next   = '0;
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_OUT_RD;
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    md_next    = {76'd0, code_reg};
                    ml_next    = 1'b1;
                    len_next   = '0;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            len_reg   <= '0;
            widx_reg  <= '0;
            lseq_reg  <= '0;
            seen_reg  <= 1'b0;
            lost_reg  <= 1'b1;
            mv_reg    <= 1'b0;
            cnt_reg   <= '0;
            grp_reg   <= '0;
            ptr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            widx_reg  <= widx_next;
            lseq_reg  <= lseq_next;
            seen_reg  <= seen_next;
            lost_reg  <= lost_next;
            mv_reg    <= mv_next;
            cnt_reg   <= cnt_next;
            grp_reg   <= grp_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        off_reg  <= off_next;
        sh_reg   <= sh_next;
        acc_reg  <= acc_next;
        code_reg <= code_next;
        md_reg   <= md_next;
        ml_reg   <= ml_next;
    end
endmodule

### hdl/dmxdf_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dmxdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
